@@ src/color_bar_pattern_generator_macros.svh @@
// Assertion macros shared by the color bar pattern generator.
// Included by the top level; depends on no other file.
`ifndef COLOR_BAR_PATTERN_GENERATOR_MACROS_SVH
`define COLOR_BAR_PATTERN_GENERATOR_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define CBPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define CBPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cbpg_pkg.sv @@
// Shared types, constants and color tables of the color bar pattern generator.
// Used by every module of the block; depends on nothing.
package cbpg_pkg;

    localparam int FW_W        = 13;   // frame width register
    localparam int FW_MAX      = 8191;
    localparam int BW_W        = FW_W - 3;
    localparam int CNT_W       = 12;   // bar pixel counter
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam logic [FW_W-1:0] FW_RESET = 13'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN = 2'd0,
        CFG_FORMAT  = 2'd1,
        CFG_WIDTH   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        FMT_YUYV     = 4'd0,
        FMT_UYVY     = 4'd1,
        FMT_YVYU     = 4'd2,
        FMT_VYUY     = 4'd3,
        FMT_RGB565   = 4'd4,
        FMT_RGB565X  = 4'd5,
        FMT_RGB555   = 4'd6,
        FMT_RGB555X  = 4'd7,
        FMT_RGB24    = 4'd8,
        FMT_BGR24    = 4'd9,
        FMT_RGB32    = 4'd10,
        FMT_BGR32    = 4'd11
    } t_fmt;

    // Selection of one pixel: which color and which column parity.
    typedef struct packed {
        logic [2:0] color;
        logic       odd;
    } t_pix_sel;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] count;
    } t_pix_bytes;

    // RGB of white, amber, cyan, green, magenta, red, blue, black.
    localparam logic [7:0] RGB_TAB [8][3] = '{
        '{8'd204, 8'd204, 8'd204},
        '{8'd208, 8'd208, 8'd0},
        '{8'd0,   8'd206, 8'd206},
        '{8'd0,   8'd239, 8'd0},
        '{8'd239, 8'd0,   8'd239},
        '{8'd205, 8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd205},
        '{8'd0,   8'd0,   8'd0}
    };

    // Color of each bar for each pattern.
    localparam logic [2:0] BAR_TAB [4][8] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd7, 3'd0, 3'd1, 3'd7, 3'd0, 3'd1},
        '{3'd0, 3'd2, 3'd7, 3'd0, 3'd2, 3'd7, 3'd0, 3'd2},
        '{3'd0, 3'd3, 3'd7, 3'd0, 3'd3, 3'd7, 3'd0, 3'd3}
    };

    // Rounded 16-bit fixed-point scale with offset, clamped at zero.
    function automatic logic [7:0] fix_scale(input int sum, input int offset);
        int t;
        t = sum + 32768 + (offset * 65536);
        if (t < 0) begin
            t = 0;
        end
        return t[23:16];
    endfunction

    function automatic logic [7:0] y_of(input int k);
        int r;
        int g;
        int b;
        r = int'(RGB_TAB[k][0]);
        g = int'(RGB_TAB[k][1]);
        b = int'(RGB_TAB[k][2]);
        return fix_scale(16829 * r + 33039 * g + 6416 * b, 16);
    endfunction

    function automatic logic [7:0] u_of(input int k);
        int r;
        int g;
        int b;
        r = int'(RGB_TAB[k][0]);
        g = int'(RGB_TAB[k][1]);
        b = int'(RGB_TAB[k][2]);
        return fix_scale(-9714 * r - 19070 * g + 28784 * b, 128);
    endfunction

    function automatic logic [7:0] v_of(input int k);
        int r;
        int g;
        int b;
        r = int'(RGB_TAB[k][0]);
        g = int'(RGB_TAB[k][1]);
        b = int'(RGB_TAB[k][2]);
        return fix_scale(28784 * r - 24103 * g - 4681 * b, 128);
    endfunction

    // Limited-range YCbCr of the eight colors, worked out at elaboration.
    localparam logic [7:0] Y_TAB [8] = '{y_of(0), y_of(1), y_of(2), y_of(3),
                                         y_of(4), y_of(5), y_of(6), y_of(7)};
    localparam logic [7:0] U_TAB [8] = '{u_of(0), u_of(1), u_of(2), u_of(3),
                                         u_of(4), u_of(5), u_of(6), u_of(7)};
    localparam logic [7:0] V_TAB [8] = '{v_of(0), v_of(1), v_of(2), v_of(3),
                                         v_of(4), v_of(5), v_of(6), v_of(7)};

endpackage

@@ src/cbpg_counter.sv @@
// Column and bar position counters of the color bar pattern generator.
// Depends on cbpg_pkg.
module cbpg_counter
    import cbpg_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_line_start,
    input  logic [1:0]      i_pattern,
    input  logic [FW_W-1:0] i_frame_width,
    output t_pix_sel        o_sel
);

    localparam int CLAMP = (MAX_WIDTH > FW_MAX) ? FW_MAX : MAX_WIDTH;
    localparam logic [FW_W-1:0] CLAMP_W = FW_W'(CLAMP);

    logic             r_odd;
    logic [CNT_W-1:0] r_cnt;
    logic [2:0]       r_bar;
    logic             n_odd;
    logic [CNT_W-1:0] n_cnt;
    logic [2:0]       n_bar;

    logic             cur_odd;
    logic [CNT_W-1:0] cur_cnt;
    logic [2:0]       cur_bar;
    logic [FW_W-1:0]  w_eff;
    logic [BW_W-1:0]  bw_raw;
    logic [BW_W-1:0]  bw;
    logic [CNT_W:0]   cnt_inc;

    // A line mark clears the position before this pixel is formed.
    always_comb begin
        cur_odd = i_line_start ? 1'b0 : r_odd;
        cur_cnt = i_line_start ? '0 : r_cnt;
        cur_bar = i_line_start ? 3'd0 : r_bar;
    end

    always_comb begin
        w_eff  = (i_frame_width > CLAMP_W) ? CLAMP_W : i_frame_width;
        bw_raw = w_eff[FW_W-1:3];
        bw     = (bw_raw == '0) ? BW_W'(1) : bw_raw;
        cnt_inc = {1'b0, cur_cnt} + (CNT_W+1)'(1);
        n_odd  = ~cur_odd;
        if (cnt_inc >= (CNT_W+1)'(bw)) begin
            n_cnt = '0;
            n_bar = cur_bar + 3'd1;
        end else begin
            n_cnt = cnt_inc[CNT_W-1:0];
            n_bar = cur_bar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd <= 1'b0;
            r_cnt <= '0;
            r_bar <= 3'd0;
        end else if (i_accept) begin
            r_odd <= n_odd;
            r_cnt <= n_cnt;
            r_bar <= n_bar;
        end
    end

    assign o_sel.color = BAR_TAB[i_pattern][cur_bar];
    assign o_sel.odd   = cur_odd;

endmodule

@@ src/cbpg_pack.sv @@
// Color conversion and byte packing for one pixel of the color bar generator.
// Depends on cbpg_pkg.
module cbpg_pack
    import cbpg_pkg::*;
(
    input  t_pix_sel   i_sel,
    input  logic [3:0] i_format,
    output t_pix_bytes o_bytes
);

    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] g5;
    logic [4:0] b5;

    always_comb begin
        r  = RGB_TAB[i_sel.color][0];
        g  = RGB_TAB[i_sel.color][1];
        b  = RGB_TAB[i_sel.color][2];
        y  = Y_TAB[i_sel.color];
        u  = U_TAB[i_sel.color];
        v  = V_TAB[i_sel.color];
        r5 = r[7:3];
        g6 = g[7:2];
        g5 = g[7:3];
        b5 = b[7:3];
    end

    always_comb begin
        o_bytes = '{b0: 8'd0, b1: 8'd0, b2: 8'd0, b3: 8'd0, count: 3'd2};
        case (i_format)
            FMT_YUYV: begin
                o_bytes.b0 = y;
                o_bytes.b1 = i_sel.odd ? v : u;
            end
            FMT_UYVY: begin
                o_bytes.b0 = i_sel.odd ? v : u;
                o_bytes.b1 = y;
            end
            FMT_YVYU: begin
                o_bytes.b0 = y;
                o_bytes.b1 = i_sel.odd ? u : v;
            end
            FMT_VYUY: begin
                o_bytes.b0 = i_sel.odd ? u : v;
                o_bytes.b1 = y;
            end
            FMT_RGB565: begin
                o_bytes.b0 = {g6[2:0], b5};
                o_bytes.b1 = {r5, g6[5:3]};
            end
            FMT_RGB565X: begin
                o_bytes.b0 = {r5, g6[5:3]};
                o_bytes.b1 = {g6[2:0], b5};
            end
            FMT_RGB555: begin
                o_bytes.b0 = {g5[2:0], b5};
                o_bytes.b1 = {1'b0, r5, g5[4:3]};
            end
            FMT_RGB555X: begin
                o_bytes.b0 = {1'b0, r5, g5[4:3]};
                o_bytes.b1 = {g5[2:0], b5};
            end
            FMT_RGB24: begin
                o_bytes.b0    = r;
                o_bytes.b1    = g;
                o_bytes.b2    = b;
                o_bytes.count = 3'd3;
            end
            FMT_BGR24: begin
                o_bytes.b0    = b;
                o_bytes.b1    = g;
                o_bytes.b2    = r;
                o_bytes.count = 3'd3;
            end
            FMT_RGB32: begin
                o_bytes.b1    = r;
                o_bytes.b2    = g;
                o_bytes.b3    = b;
                o_bytes.count = 3'd4;
            end
            FMT_BGR32: begin
                o_bytes.b0    = b;
                o_bytes.b1    = g;
                o_bytes.b2    = r;
                o_bytes.count = 3'd4;
            end
            default: begin
                // Unknown formats give zero bytes and a count of two.
                o_bytes.count = 3'd2;
            end
        endcase
    end

endmodule

@@ src/color_bar_pattern_generator.sv @@
// Top level of the color bar pattern generator: configuration registers,
// handshake and output register. Depends on cbpg_pkg, cbpg_counter, cbpg_pack.
//
// Usage. Each word on the input channel (i_in_valid / o_in_ready) is one
// pixel slot; i_line_start marks the first pixel of a line and restarts the
// bar walk at column zero. For every accepted word exactly one word leaves on
// the output channel (o_out_valid / i_out_ready): up to four packed bytes and
// o_byte_count, the number of bytes that the selected format uses.
// A word accepted in one cycle is presented in the next. Throughput is one
// word per cycle while the receiver does not stall; the position counters
// and the pixel logic are a single registered step, and the output register
// is the only storage between the two channels. When the receiver stalls,
// the output register holds its word and o_in_ready falls; it rises again
// in the cycle the word is taken, so a new word may enter in the same cycle
// the old one leaves. Reset (synchronous, active low) clears the counters
// and the output valid and returns pattern 0, format YUYV and a frame width
// of 640. Configuration is to be written through i_cfg_we / i_cfg_idx /
// i_cfg_data while the block is idle; the block does not enforce this.
`include "color_bar_pattern_generator_macros.svh"

module color_bar_pattern_generator
    import cbpg_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_line_start,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_byte0,
    output logic [7:0]            o_byte1,
    output logic [7:0]            o_byte2,
    output logic [7:0]            o_byte3,
    output logic [2:0]            o_byte_count
);

    logic [1:0]      r_pattern;
    logic [3:0]      r_format;
    logic [FW_W-1:0] r_frame_width;
    logic            r_out_valid;
    t_pix_bytes      r_bytes;

    logic       in_accept;
    t_pix_sel   sel;
    t_pix_bytes pix_bytes;

    // The output register can take a new word when it is empty or being read.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Configuration registers; writes to an index past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= 2'd0;
            r_format      <= FMT_YUYV;
            r_frame_width <= FW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN: r_pattern     <= i_cfg_data[1:0];
                CFG_FORMAT:  r_format      <= i_cfg_data[3:0];
                CFG_WIDTH:   r_frame_width <= i_cfg_data[FW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cbpg_counter #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_counter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_line_start  (i_line_start),
        .i_pattern     (r_pattern),
        .i_frame_width (r_frame_width),
        .o_sel         (sel)
    );

    cbpg_pack u_pack (
        .i_sel    (sel),
        .i_format (r_format),
        .o_bytes  (pix_bytes)
    );

    // Output valid is control state; the payload loads on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_bytes <= pix_bytes;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte0      = r_bytes.b0;
    assign o_byte1      = r_bytes.b1;
    assign o_byte2      = r_bytes.b2;
    assign o_byte3      = r_bytes.b3;
    assign o_byte_count = r_bytes.count;

    // Every accepted word shows up on the output in the next cycle.
    `CBPG_ASSERT_NEXT(a_accept_shows, i_clk, i_rst_n, in_accept, o_out_valid,
        "accepted word did not reach the output register")
    // Two-byte formats leave the upper bytes at zero.
    `CBPG_ASSERT_NOW(a_two_byte_zero, i_clk, i_rst_n,
        o_out_valid && (o_byte_count == 3'd2), (o_byte2 == 8'd0) && (o_byte3 == 8'd0),
        "unused bytes are not zero for a two-byte format")
    // Only 32-bit formats use the fourth byte.
    `CBPG_ASSERT_NOW(a_byte3_use, i_clk, i_rst_n,
        o_out_valid && (o_byte_count != 3'd4), o_byte3 == 8'd0,
        "fourth byte set for a format that does not use it")

endmodule
